### rtl/spc_pkg.sv
`timescale 1ns / 1ps

package spc_pkg;

	localparam int VCOUNT_BITS = 5;
	localparam int TOL_BITS = 10;
	localparam int INDEX_BITS = 4;
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS = 10;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEST = 1'b1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_VERTEX_COUNT = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TOLERANCE = 1'd1;

	typedef struct packed {
		logic valid;
		logic ok;
	} link_t;

endpackage

### rtl/spc_cell.sv
`timescale 1ns / 1ps

module spc_cell #(
	parameter int COORD_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load_en,
	input  logic signed [COORD_BITS-1:0]       load_x,
	input  logic signed [COORD_BITS-1:0]       load_y,
	input  logic signed [COORD_BITS-1:0]       load_z,
	input  logic signed [COORD_BITS-1:0]       next_x,
	input  logic signed [COORD_BITS-1:0]       next_y,
	input  logic signed [COORD_BITS-1:0]       next_z,
	input  logic                               active,
	input  logic [spc_pkg::TOL_BITS-1:0]       tolerance,
	input  spc_pkg::link_t                     link_in,
	input  logic signed [COORD_BITS-1:0]       pin_x,
	input  logic signed [COORD_BITS-1:0]       pin_y,
	input  logic signed [COORD_BITS-1:0]       pin_z,
	output logic signed [COORD_BITS-1:0]       vert_x,
	output logic signed [COORD_BITS-1:0]       vert_y,
	output logic signed [COORD_BITS-1:0]       vert_z,
	output spc_pkg::link_t                     link_out,
	output logic signed [COORD_BITS-1:0]       pout_x,
	output logic signed [COORD_BITS-1:0]       pout_y,
	output logic signed [COORD_BITS-1:0]       pout_z
);

	localparam int PW = 2 * COORD_BITS;
	localparam int XW = 2 * COORD_BITS + 1;
	localparam int DW = 3 * COORD_BITS + 1;
	localparam int SW = 3 * COORD_BITS + 4;

	logic signed [COORD_BITS-1:0] vx_q, vy_q, vz_q;
	logic signed [XW-1:0] cx_q, cy_q, cz_q;
	logic signed [XW-1:0] cx_d, cy_d, cz_d;
	logic signed [PW-1:0] m0, m1, m2, m3, m4, m5;

	spc_pkg::link_t link_s1, link_s2;
	logic signed [COORD_BITS-1:0] px_s1, py_s1, pz_s1;
	logic signed [COORD_BITS-1:0] px_s2, py_s2, pz_s2;
	logic signed [DW-1:0] dx_s2, dy_s2, dz_s2;
	logic signed [SW-1:0] sum;

	always_ff @(posedge clk) begin
		if (load_en) begin
			vx_q <= load_x;
			vy_q <= load_y;
			vz_q <= load_z;
		end
	end

	// The edge normal follows the stored vertices and the vertex count.
	always_comb begin
		m0 = PW'(vy_q) * PW'(next_z);
		m1 = PW'(vz_q) * PW'(next_y);
		m2 = PW'(vx_q) * PW'(next_z);
		m3 = PW'(vz_q) * PW'(next_x);
		m4 = PW'(vx_q) * PW'(next_y);
		m5 = PW'(vy_q) * PW'(next_x);
		cx_d = XW'(m0) - XW'(m1);
		cy_d = XW'(m2) - XW'(m3);
		cz_d = XW'(m4) - XW'(m5);
	end

	always_ff @(posedge clk) begin
		cx_q <= cx_d;
		cy_q <= cy_d;
		cz_q <= cz_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_s1 <= '0;
			link_s2 <= '0;
		end else begin
			link_s1 <= link_in;
			link_s2 <= link_s1;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= pin_x;
		py_s1 <= pin_y;
		pz_s1 <= pin_z;
		px_s2 <= px_s1;
		py_s2 <= py_s1;
		pz_s2 <= pz_s1;
		dx_s2 <= DW'(px_s1) * DW'(cx_q);
		dy_s2 <= DW'(py_s1) * DW'(cy_q);
		dz_s2 <= DW'(pz_s1) * DW'(cz_q);
	end

	always_comb begin
		sum = SW'(dx_s2) - SW'(dy_s2) + SW'(dz_s2) + $signed(SW'(tolerance));
		link_out.valid = link_s2.valid;
		link_out.ok = link_s2.ok & (!active | !sum[SW-1]);
	end

	assign pout_x = px_s2;
	assign pout_y = py_s2;
	assign pout_z = pz_s2;
	assign vert_x = vx_q;
	assign vert_y = vy_q;
	assign vert_z = vz_q;

endmodule

### rtl/spc_out_queue.sv
`timescale 1ns / 1ps

module spc_out_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic push_data,
	input  logic pop,
	output logic head_valid,
	output logic head_data,
	output logic full
);

	logic [1:0] cnt_q;
	logic q0_q, q1_q;
	logic to_second;

	assign head_valid = (cnt_q != 2'd0);
	assign head_data = q0_q;
	assign full = (cnt_q == 2'd2);
	assign to_second = (cnt_q == 2'd2) || ((cnt_q == 2'd1) && !pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !to_second) begin
			q0_q <= push_data;
		end else if (pop) begin
			q0_q <= q1_q;
		end
		if (push && to_second) begin
			q1_q <= push_data;
		end
	end

endmodule

### rtl/spherical_polygon_contains.sv
`timescale 1ns / 1ps

// Point in convex spherical polygon test.
// Input channel (in_valid/in_ready): a request with op load writes one vertex
// (coord_x/y/z, signed Q1.15) into slot vertex_index; op test carries a point.
// Output channel (out_valid/out_ready): one inside_res per test request, in order.
// Configuration (cfg_we/cfg_index/cfg_data): vertex_count and tolerance. The user
// must write them only while the block is idle; the block does not enforce it.
// A test request walks a row of MAX_VERTICES cells, one edge per cell, each cell
// passing it through its link_s1 and link_s2 registers before the result is
// queued. Tests are taken one at a time: a new request is accepted only after
// busy_q clears, which happens as the previous result is queued. Loads give no
// result and leave the input ready for the next request.
// A two-entry result queue lets the next request enter while a result waits;
// input stalls while a test is in flight, or when a stalled receiver holds both.
// Reset clears the configuration, the cell row and the result queue; vertex
// slots hold no defined value until they are loaded.
module spherical_polygon_contains #(
	parameter int MAX_VERTICES = 16,
	parameter int COORD_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 op,
	input  logic [spc_pkg::INDEX_BITS-1:0]       vertex_index,
	input  logic signed [COORD_BITS-1:0]         coord_x,
	input  logic signed [COORD_BITS-1:0]         coord_y,
	input  logic signed [COORD_BITS-1:0]         coord_z,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 inside_res,
	input  logic                                 cfg_we,
	input  logic [spc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [spc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	localparam int KW = $clog2(MAX_VERTICES + 1);

	logic [spc_pkg::VCOUNT_BITS-1:0] vertex_count_q;
	logic [spc_pkg::TOL_BITS-1:0] tolerance_q;
	logic [KW-1:0] k_eff;
	logic busy_q;
	logic accept, load_acc, test_acc;
	logic q_full;

	spc_pkg::link_t link [MAX_VERTICES+1];
	logic signed [COORD_BITS-1:0] px_c [MAX_VERTICES+1];
	logic signed [COORD_BITS-1:0] py_c [MAX_VERTICES+1];
	logic signed [COORD_BITS-1:0] pz_c [MAX_VERTICES+1];
	logic signed [COORD_BITS-1:0] vx_v [MAX_VERTICES];
	logic signed [COORD_BITS-1:0] vy_v [MAX_VERTICES];
	logic signed [COORD_BITS-1:0] vz_v [MAX_VERTICES];

	assign in_ready = !busy_q && !q_full;
	assign accept = in_valid && in_ready;
	assign load_acc = accept && (op == spc_pkg::OP_LOAD);
	assign test_acc = accept && (op == spc_pkg::OP_TEST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
			tolerance_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spc_pkg::REG_VERTEX_COUNT: vertex_count_q <= cfg_data[spc_pkg::VCOUNT_BITS-1:0];
				spc_pkg::REG_TOLERANCE:    tolerance_q <= cfg_data[spc_pkg::TOL_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(vertex_count_q) > 32'(MAX_VERTICES)) begin
			k_eff = KW'(MAX_VERTICES);
		end else begin
			k_eff = KW'(vertex_count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (test_acc) begin
			busy_q <= 1'b1;
		end else if (link[MAX_VERTICES].valid) begin
			busy_q <= 1'b0;
		end
	end

	assign link[0].valid = test_acc;
	assign link[0].ok = 1'b1;
	assign px_c[0] = coord_x;
	assign py_c[0] = coord_y;
	assign pz_c[0] = coord_z;

	for (genvar gi = 0; gi < MAX_VERTICES; gi++) begin : g_cell
		localparam int NI = (gi + 1) % MAX_VERTICES;
		logic wrap;
		logic cell_active;
		logic cell_load;

		assign wrap = (KW'(gi + 1) == k_eff);
		assign cell_active = (KW'(gi) < k_eff);
		assign cell_load = load_acc && (int'(vertex_index) == gi);

		spc_cell #(
			.COORD_BITS(COORD_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load_en  (cell_load),
			.load_x   (coord_x),
			.load_y   (coord_y),
			.load_z   (coord_z),
			.next_x   (wrap ? vx_v[0] : vx_v[NI]),
			.next_y   (wrap ? vy_v[0] : vy_v[NI]),
			.next_z   (wrap ? vz_v[0] : vz_v[NI]),
			.active   (cell_active),
			.tolerance(tolerance_q),
			.link_in  (link[gi]),
			.pin_x    (px_c[gi]),
			.pin_y    (py_c[gi]),
			.pin_z    (pz_c[gi]),
			.vert_x   (vx_v[gi]),
			.vert_y   (vy_v[gi]),
			.vert_z   (vz_v[gi]),
			.link_out (link[gi+1]),
			.pout_x   (px_c[gi+1]),
			.pout_y   (py_c[gi+1]),
			.pout_z   (pz_c[gi+1])
		);
	end

	spc_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (link[MAX_VERTICES].valid),
		.push_data (link[MAX_VERTICES].ok),
		.pop       (out_valid && out_ready),
		.head_valid(out_valid),
		.head_data (inside_res),
		.full      (q_full)
	);

endmodule

### rtl/spc_checker.sv
`timescale 1ns / 1ps

module spc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic op,
	input logic out_valid,
	input logic out_ready,
	input logic inside_res
);

	// A held result must not change or vanish.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(inside_res))
		else $error("result changed while stalled");

	// A test request occupies the cell row, so no request follows at once.
	a_test_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == spc_pkg::OP_TEST |=> !in_ready)
		else $error("request accepted while a test is in flight");

	// A load never blocks the channel.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == spc_pkg::OP_LOAD |=> in_ready)
		else $error("load request blocked the input");

endmodule

bind spherical_polygon_contains spc_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.op        (op),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.inside_res(inside_res)
);

### tb/tb_spherical_polygon_contains.sv
`timescale 1ns / 1ps

module tb_spherical_polygon_contains;

	localparam int NV = 16;
	localparam int CB = 16;
	localparam int ITEM_TARGET = 1650;
	localparam int DRAIN_CYCLES = 2 * NV + 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam real PI = 3.14159265358979;

	typedef logic [spc_pkg::INDEX_BITS-1:0] slot_t;

	typedef struct packed {
		logic op;
		slot_t slot;
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic signed [CB-1:0] z;
	} geo_req_t;

	typedef enum {POLY_SPHERE, POLY_TINY} poly_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic op;
	slot_t vertex_index;
	logic signed [CB-1:0] coord_x;
	logic signed [CB-1:0] coord_y;
	logic signed [CB-1:0] coord_z;
	logic out_valid;
	logic out_ready = 1'b0;
	logic inside_res;
	logic cfg_we = 1'b0;
	logic [spc_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [spc_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

	geo_req_t cur_req = '0;
	geo_req_t pending_requests[$];
	bit inside_expected[$];

	logic signed [CB-1:0] vtx_x[NV];
	logic signed [CB-1:0] vtx_y[NV];
	logic signed [CB-1:0] vtx_z[NV];
	logic signed [CB-1:0] plan_x[NV];
	logic signed [CB-1:0] plan_y[NV];
	logic signed [CB-1:0] plan_z[NV];
	logic [spc_pkg::VCOUNT_BITS-1:0] vcount_reg = '0;
	logic [spc_pkg::TOL_BITS-1:0] tol_reg = '0;

	int error_count = 0;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;
	int unsigned in_gap = 0;
	int unsigned out_gap = 0;
	bit drv_busy = 1'b0;
	bit idle_on = 1'b1;
	bit got_inside;
	real ax, ay, az, ux, uy, uz, wx, wy, wz;
	real phase_cap = 0.5;

	assign op = cur_req.op;
	assign vertex_index = cur_req.slot;
	assign coord_x = cur_req.x;
	assign coord_y = cur_req.y;
	assign coord_z = cur_req.z;

	spherical_polygon_contains #(
		.MAX_VERTICES(NV),
		.COORD_BITS(CB)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.vertex_index(vertex_index),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.inside_res(inside_res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic bit point_inside(logic signed [CB-1:0] px, logic signed [CB-1:0] py,
			logic signed [CB-1:0] pz);
		int unsigned k;
		int unsigned i;
		int unsigned j;
		longint cx, cy, cz, d;
		bit result;
		k = (vcount_reg > NV) ? NV : vcount_reg;
		result = 1'b1;
		for (i = 0; i < k; i++) begin
			j = (i + 1 == k) ? 0 : i + 1;
			cx = longint'(vtx_y[i]) * longint'(vtx_z[j]) - longint'(vtx_z[i]) * longint'(vtx_y[j]);
			cy = longint'(vtx_x[i]) * longint'(vtx_z[j]) - longint'(vtx_z[i]) * longint'(vtx_x[j]);
			cz = longint'(vtx_x[i]) * longint'(vtx_y[j]) - longint'(vtx_y[i]) * longint'(vtx_x[j]);
			d = longint'(px) * cx - longint'(py) * cy + longint'(pz) * cz + longint'(tol_reg);
			if (d < 0) begin
				result = 1'b0;
			end
		end
		return result;
	endfunction

	task automatic take_request(geo_req_t r);
		if (r.op == spc_pkg::OP_LOAD) begin
			vtx_x[r.slot] = r.x;
			vtx_y[r.slot] = r.y;
			vtx_z[r.slot] = r.z;
		end else begin
			inside_expected.push_back(point_inside(r.x, r.y, r.z));
		end
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!idle_on) begin
			return 0;
		end
		r = $urandom_range(99);
		if (r < 65) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(3, 1);
		end else if (r < 97) begin
			return $urandom_range(12, 4);
		end
		return $urandom_range(60, 20);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap = 0;
			drv_busy = 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				take_request(cur_req);
				drv_busy = 1'b0;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					cur_req <= pending_requests.pop_front();
					in_valid <= 1'b1;
					drv_busy = 1'b1;
					in_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (inside_expected.size() == 0) begin
					$error("inside_res: expected no result, actual %0b", inside_res);
					error_count++;
				end else begin
					got_inside = inside_expected.pop_front();
					if (inside_res !== got_inside) begin
						$error("inside_res: expected %0b, actual %0b", got_inside, inside_res);
						error_count++;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				out_gap = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic real urand_real(real lo, real hi);
		return lo + (hi - lo) * real'($urandom_range(1000000)) / 1000000.0;
	endfunction

	function automatic int to_q15(real v);
		real t;
		int q;
		t = v * 32767.0;
		q = (t >= 0.0) ? $rtoi(t + 0.5) : $rtoi(t - 0.5);
		if (q > 32767) begin
			q = 32767;
		end
		if (q < -32767) begin
			q = -32767;
		end
		return q;
	endfunction

	function automatic int sat16(int v);
		if (v > 32767) begin
			return 32767;
		end
		if (v < -32768) begin
			return -32768;
		end
		return v;
	endfunction

	function automatic geo_req_t make_req(logic o, slot_t s, int x, int y, int z);
		geo_req_t r;
		r.op = o;
		r.slot = s;
		r.x = 16'(x);
		r.y = 16'(y);
		r.z = 16'(z);
		return r;
	endfunction

	// Point at angular distance off from the frame axis, at azimuth ang.
	function automatic geo_req_t sphere_req(logic o, slot_t s, real off, real ang);
		real c, sn, ca, sa;
		c = $cos(off);
		sn = $sin(off);
		ca = $cos(ang);
		sa = $sin(ang);
		return make_req(o, s, to_q15(c * ax + sn * (ca * ux + sa * wx)),
			to_q15(c * ay + sn * (ca * uy + sa * wy)), to_q15(c * az + sn * (ca * uz + sa * wz)));
	endfunction

	function automatic int small_coord(int unsigned span);
		return int'($urandom_range(2 * span)) - int'(span);
	endfunction

	task automatic push_item(geo_req_t r);
		if (r.op == spc_pkg::OP_LOAD) begin
			plan_x[r.slot] = r.x;
			plan_y[r.slot] = r.y;
			plan_z[r.slot] = r.z;
		end
		pending_requests.push_back(r);
		items_sent++;
	endtask

	task automatic pick_frame();
		real n;
		n = 0.0;
		while (n < 0.05 || n > 1.0) begin
			ax = urand_real(-1.0, 1.0);
			ay = urand_real(-1.0, 1.0);
			az = urand_real(-1.0, 1.0);
			n = ax * ax + ay * ay + az * az;
		end
		n = $sqrt(n);
		ax = ax / n;
		ay = ay / n;
		az = az / n;
		if (ax < 0.6 && ax > -0.6) begin
			ux = 0.0;
			uy = az;
			uz = -ay;
		end else begin
			ux = -az;
			uy = 0.0;
			uz = ax;
		end
		n = $sqrt(ux * ux + uy * uy + uz * uz);
		ux = ux / n;
		uy = uy / n;
		uz = uz / n;
		wx = ay * uz - az * uy;
		wy = az * ux - ax * uz;
		wz = ax * uy - ay * ux;
	endtask

	task automatic load_polygon(int unsigned k, poly_kind_t kind);
		int unsigned n;
		int unsigned s;
		bit down;
		down = 1'($urandom_range(1));
		phase_cap = urand_real(0.15, 1.3);
		for (n = 0; n < k; n++) begin
			s = down ? k - 1 - n : n;
			if (kind == POLY_TINY) begin
				push_item(make_req(spc_pkg::OP_LOAD, slot_t'(s), small_coord(2), small_coord(2),
					small_coord(2)));
			end else begin
				push_item(sphere_req(spc_pkg::OP_LOAD, slot_t'(s), phase_cap,
					(2.0 * PI / k) * (real'(s) + urand_real(-0.25, 0.25))));
			end
		end
	endtask

	task automatic push_probe(poly_kind_t kind, int unsigned k);
		int unsigned r;
		int unsigned i;
		int unsigned j;
		int unsigned span;
		int sx, sy, sz;
		r = $urandom_range(99);
		if (r >= 94) begin
			push_item(make_req(1'($urandom_range(1)), slot_t'($urandom), $urandom, $urandom,
				$urandom));
		end else if (r >= 78 && k > 0) begin
			// Points on or right next to an edge plane.
			i = $urandom_range(k - 1);
			j = (i + 1 == k) ? 0 : i + 1;
			sx = (int'(plan_x[i]) + int'(plan_x[j])) / 2 + int'($urandom_range(2)) - 1;
			sy = (int'(plan_y[i]) + int'(plan_y[j])) / 2 + int'($urandom_range(2)) - 1;
			sz = (int'(plan_z[i]) + int'(plan_z[j])) / 2 + int'($urandom_range(2)) - 1;
			push_item(make_req(spc_pkg::OP_TEST, slot_t'($urandom), sat16(sx), sat16(sy),
				sat16(sz)));
		end else if (kind == POLY_TINY) begin
			case ($urandom_range(2))
				0: span = 50;
				1: span = 400;
				default: span = 4000;
			endcase
			push_item(make_req(spc_pkg::OP_TEST, slot_t'($urandom), small_coord(span),
				small_coord(span), small_coord(span)));
		end else if (r < 40) begin
			push_item(sphere_req(spc_pkg::OP_TEST, slot_t'($urandom),
				phase_cap * urand_real(0.0, 0.9), urand_real(0.0, 2.0 * PI)));
		end else if (r < 70) begin
			push_item(sphere_req(spc_pkg::OP_TEST, slot_t'($urandom),
				phase_cap * urand_real(0.9, 1.6), urand_real(0.0, 2.0 * PI)));
		end else begin
			push_item(sphere_req(spc_pkg::OP_TEST, slot_t'($urandom), urand_real(0.0, PI),
				urand_real(0.0, 2.0 * PI)));
		end
	endtask

	task automatic write_reg(logic [spc_pkg::CFG_INDEX_BITS-1:0] idx,
			logic [spc_pkg::CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == spc_pkg::REG_VERTEX_COUNT) begin
			vcount_reg = val[spc_pkg::VCOUNT_BITS-1:0];
		end else begin
			tol_reg = val[spc_pkg::TOL_BITS-1:0];
		end
	endtask

	task automatic wait_drained();
		while (pending_requests.size() != 0 || drv_busy || inside_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned phase;
		int unsigned n;
		int unsigned kk;
		logic [4:0] vc;
		logic [4:0] pad;
		logic [spc_pkg::TOL_BITS-1:0] tv;
		poly_kind_t kind;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every slot gets a vertex first, so no test ever reads an unwritten one.
		write_reg(spc_pkg::REG_VERTEX_COUNT, '0);
		write_reg(spc_pkg::REG_TOLERANCE, '0);
		pick_frame();
		load_polygon(NV, POLY_SPHERE);
		push_item(make_req(spc_pkg::OP_TEST, 4'hF, 32767, 32767, 32767));
		push_item(make_req(spc_pkg::OP_TEST, 4'h0, -32768, -32768, -32768));
		wait_drained();

		// A single vertex forms a degenerate edge onto itself.
		write_reg(spc_pkg::REG_VERTEX_COUNT, 10'd1);
		write_reg(spc_pkg::REG_TOLERANCE, 10'd1023);
		push_item(make_req(spc_pkg::OP_TEST, 4'h5, 32767, -32768, 0));
		push_item(sphere_req(spc_pkg::OP_TEST, 4'hA, 0.0, 0.0));
		wait_drained();

		// A count above the store size uses every slot.
		write_reg(spc_pkg::REG_VERTEX_COUNT, {5'b10101, 5'd31});
		write_reg(spc_pkg::REG_TOLERANCE, '0);
		push_item(make_req(spc_pkg::OP_LOAD, 4'hF, -32768, 32767, -32768));
		push_item(make_req(spc_pkg::OP_LOAD, 4'h0, 32767, -32768, 32767));
		push_item(sphere_req(spc_pkg::OP_TEST, 4'h3, 0.0, 0.0));
		push_item(sphere_req(spc_pkg::OP_TEST, 4'hC, PI, 0.0));
		push_item(make_req(spc_pkg::OP_TEST, 4'h7, -32768, -32768, -32768));
		push_item(make_req(spc_pkg::OP_TEST, 4'h8, 0, 0, 0));

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			wait_drained();
			idle_on = (phase % 4 != 2);
			case (phase)
				0: vc = 5'd3;
				1: vc = 5'd16;
				2: vc = 5'd31;
				3: vc = 5'd2;
				4: vc = 5'd0;
				5: vc = 5'd17;
				default: vc = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) :
					5'($urandom_range(16, 3));
			endcase
			case ((phase < 2) ? phase : $urandom_range(3))
				0: tv = '0;
				1: tv = 10'd1023;
				default: tv = 10'($urandom_range(1023));
			endcase
			pad = 5'($urandom);
			write_reg(spc_pkg::REG_VERTEX_COUNT, {pad, vc});
			write_reg(spc_pkg::REG_TOLERANCE, tv);
			kk = (vc > NV) ? NV : vc;
			kind = (phase % 3 == 1) ? POLY_TINY : POLY_SPHERE;
			pick_frame();
			load_polygon(kk, kind);
			n = $urandom_range(140, 80);
			repeat (n) push_probe(kind, kk);
			phase++;
		end
		wait_drained();

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### sim.f
rtl/spc_pkg.sv
rtl/spc_cell.sv
rtl/spc_out_queue.sv
rtl/spherical_polygon_contains.sv
rtl/spc_checker.sv
tb/tb_spherical_polygon_contains.sv
